// ===== rtl/core/b64enc_pkg.sv =====
// Shared types, ASCII constants and the sextet-to-character mapping of the base64 encoder.
`default_nettype none

package b64enc_pkg;

   localparam logic [6:0] ASCII_UPPER_A = 7'h41;
   localparam logic [6:0] ASCII_LOWER_A = 7'h61;
   localparam logic [6:0] ASCII_DIGIT_0 = 7'h30;
   localparam logic [6:0] ASCII_PLUS    = 7'h2B;
   localparam logic [6:0] ASCII_SLASH   = 7'h2F;

   // Up to two characters produced by one byte
   typedef struct packed {
      logic [6:0] char0;
      logic       last0;
      logic [6:0] char1;
      logic       last1;
      logic       two;
   } char_pair_type;

   function automatic logic [6:0] sextet_to_ascii(input logic [5:0] sextet);
      logic [6:0] v;
      v = {1'b0, sextet};
      if (sextet < 6'd26) begin
         return ASCII_UPPER_A + v;
      end else if (sextet < 6'd52) begin
         return ASCII_LOWER_A + (v - 7'd26);
      end else if (sextet < 6'd62) begin
         return ASCII_DIGIT_0 + (v - 7'd52);
      end else if (sextet == 6'd62) begin
         return ASCII_PLUS;
      end else begin
         return ASCII_SLASH;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b64enc_req_if.sv =====
// Byte channel of the base64 encoder: valid/ready with one raw byte and an end-of-message flag.
`default_nettype none

interface b64enc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;
   logic       last_byte;

   modport source (output valid, output byte_in, output last_byte, input ready);
   modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/b64enc_rsp_if.sv =====
// Character channel of the base64 encoder: valid/ready with one ASCII code and a final flag.
`default_nettype none

interface b64enc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/b64enc_encode.sv =====
// Input register, group phase tracking and sextet formation for the base64 encoder.
`default_nettype none

module b64enc_encode (
   input  wire                    clock,
   input  wire                    reset,
   b64enc_req_if.sink             req,
   output logic                   pair_valid,
   input  wire                    pair_ready,
   output b64enc_pkg::char_pair_type pair
);

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       advance;
   logic [5:0] sextet0, sextet1;

   assign advance   = in_valid_ff && pair_ready;
   assign req.ready = !in_valid_ff || pair_ready;
   assign pair_valid = in_valid_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
      end
   end

   always_comb begin
      sextet0    = byte_ff[7:2];
      sextet1    = {byte_ff[1:0], 4'b0000};
      pair.last0 = 1'b0;
      pair.last1 = last_ff;
      pair.two   = last_ff;
      phase_in   = PHASE_1;
      left_in    = {2'b00, byte_ff[1:0]};
      unique case (phase_ff)
         PHASE_1: begin
            sextet0  = {left_ff[1:0], byte_ff[7:4]};
            sextet1  = {byte_ff[3:0], 2'b00};
            phase_in = PHASE_2;
            left_in  = byte_ff[3:0];
         end
         PHASE_2: begin
            sextet0  = {left_ff, byte_ff[7:6]};
            sextet1  = byte_ff[5:0];
            pair.two = 1'b1;
            phase_in = PHASE_0;
            left_in  = 4'd0;
         end
         default: begin
            // phase 0, and the unused code behaves the same
         end
      endcase
      if (last_ff) begin
         phase_in = PHASE_0;
         left_in  = 4'd0;
      end
      pair.char0 = b64enc_pkg::sextet_to_ascii(sextet0);
      pair.char1 = b64enc_pkg::sextet_to_ascii(sextet1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PHASE_0;
         left_ff     <= 4'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            left_ff  <= left_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         byte_ff <= req.byte_in;
         last_ff <= req.last_byte;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/b64enc_out_buf.sv =====
// Two-slot result register that serialises a character pair onto the character channel.
`default_nettype none

module b64enc_out_buf (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       pair_valid,
   output logic                      pair_ready,
   input  b64enc_pkg::char_pair_type pair,
   b64enc_rsp_if.source              rsp
);

   logic       head_valid_ff, head_valid_in;
   logic       tail_valid_ff, tail_valid_in;
   logic [6:0] head_char_ff, tail_char_ff;
   logic       head_last_ff, tail_last_ff;
   logic       load, pop;

   assign pair_ready = !tail_valid_ff && (!head_valid_ff || rsp.ready);
   assign load       = pair_valid && pair_ready;
   assign pop        = head_valid_ff && rsp.ready;

   assign rsp.valid    = head_valid_ff;
   assign rsp.out_char = head_char_ff;
   assign rsp.out_last = head_last_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      tail_valid_in = tail_valid_ff;
      if (load) begin
         head_valid_in = 1'b1;
         tail_valid_in = pair.two;
      end else if (pop) begin
         head_valid_in = tail_valid_ff;
         tail_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         head_char_ff <= pair.char0;
         head_last_ff <= pair.last0;
         tail_char_ff <= pair.char1;
         tail_last_ff <= pair.last1;
      end else if (pop) begin
         head_char_ff <= tail_char_ff;
         head_last_ff <= tail_last_ff;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/base64_stream_encoder.sv =====
// Streaming base64 encoder top level: one raw byte per beat in, one ASCII character per beat out.
// Usage:
//  - req carries one data byte per beat; last_byte marks the final byte of a message.
//  - rsp carries one character per beat from the standard alphabet, as 7-bit ASCII;
//    out_last flags the final character of a message. No '=' padding is sent; the
//    tail bits of a short group go out zero-filled in one extra character.
//  - Bytes at the first and second place of a group give one character, the third
//    gives two; a last byte at the first or second place gives two as well.
// Path: a byte is held in the input register, then its first character is loaded into
//    the result register, which drives rsp; a stall on either side can hold it between.
// Throughput: one byte per cycle while each byte yields a single character and rsp is
//    ready; a byte yielding two keeps the next pair out until its first character has
//    left, so the one-character result channel sets the worst case.
// Reset: synchronous, clears the group phase, the leftover bits and all valid flags;
//    the block is ready for a new message as soon as reset is released.
// Stalls: an input register and a two-slot result register part the channels. While
//    rsp is held off, one more byte is still taken into the input register; after
//    that req.ready stays low until characters drain. Nothing is dropped or repeated.
`default_nettype none

module base64_stream_encoder (
   input  wire          clock,
   input  wire          reset,
   b64enc_req_if.sink   req,
   b64enc_rsp_if.source rsp
);

   logic                      pair_valid;
   logic                      pair_ready;
   b64enc_pkg::char_pair_type pair;

   // Byte register, phase/leftover state and character lookup
   b64enc_encode u_encode (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .pair_valid (pair_valid),
      .pair_ready (pair_ready),
      .pair       (pair)
   );

   // Result register: takes a pair, hands out one character per beat
   b64enc_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .pair_valid (pair_valid),
      .pair_ready (pair_ready),
      .pair       (pair),
      .rsp        (rsp)
   );

endmodule

`default_nettype wire
